// File: rtl/mbrtu_pkg.sv
// shared constants and the crc step function for the modbus rtu slave engine
`default_nettype none
package mbrtu_pkg;
    localparam int NUM_REGS_DEF  = 32;
    localparam int BUF_BYTES_DEF = 64;

    localparam logic [1:0] OP_RX_BYTE = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_LWRITE  = 2'd2;
    localparam logic [1:0] OP_LREAD   = 2'd3;

    localparam logic [1:0] CFG_NODE_ADDR = 2'd0;
    localparam logic [1:0] CFG_GAP_TICKS = 2'd1;
    localparam logic [1:0] CFG_CRC_EXC   = 2'd2;

    localparam logic [7:0] FN_READ      = 8'h03;
    localparam logic [7:0] FN_WRITE     = 8'h06;
    localparam logic [7:0] EXC_FLAG     = 8'h80;
    localparam logic [7:0] EXC_ILL_FUNC = 8'h01;
    localparam logic [7:0] EXC_ILL_ADDR = 8'h02;
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;
    localparam logic [15:0] READ_MISS   = 16'hFFFF;
    localparam logic [5:0]  READ_CAP    = 6'd29;

    // one crc step over a whole byte, eight shifts of the 16-bit value
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction
endpackage
`default_nettype wire

// File: rtl/mbrtu_crc.sv
// crc-16 accumulator, one byte per cycle while en is high
`default_nettype none
module mbrtu_crc
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        clear,
    input  wire logic        en,
    input  wire logic [7:0]  din,
    output logic      [15:0] crc
);
    logic [15:0] crc_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            crc_reg <= mbrtu_pkg::CRC_INIT;
        else if (clear)
            crc_reg <= mbrtu_pkg::CRC_INIT;
        else if (en)
            crc_reg <= mbrtu_pkg::crc_byte(crc_reg, din);
    end
    assign crc = crc_reg;
endmodule
`default_nettype wire

// File: rtl/modbus_rtu_slave_engine_core.sv
// top level of the modbus rtu slave engine
`default_nettype none
// a byte, a tick that does not end a frame, and a local write are taken while idle and keep
//   busy low; a local read passes through S_LREAD, which registers its strobe
// frame end: S_FETCH, the S_CRCRUN walk over the buffered bytes, then S_CRCCMP, S_DECIDE
//   and S_RDREG as needed; each reply byte leaves S_EMIT, with S_EMITW between bytes
// results cannot be stalled; busy drops in the cycle of the last strobe
// reset loads config 1/3/4, clears control, then clears NUM_REGS registers while busy
module modbus_rtu_slave_engine_core
#(
    parameter int NUM_REGS  = mbrtu_pkg::NUM_REGS_DEF,
    parameter int BUF_BYTES = mbrtu_pkg::BUF_BYTES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  opcode,
    input  wire logic [7:0]  rx_byte,
    input  wire logic [15:0] reg_index,
    input  wire logic [15:0] reg_value,
    output logic             strobe,
    output logic             kind,
    output logic      [15:0] data,
    output logic             last,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);
    localparam int RW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int BW = $clog2(BUF_BYTES);
    localparam int LW = BW + 1;
    localparam logic [16:0] NREGS17 = 17'(NUM_REGS);
    localparam logic [LW-1:0] BUF_FULL = LW'(BUF_BYTES);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_LREAD, S_FETCH, S_CRCRUN, S_CRCCMP, S_DECIDE,
        S_RDREG, S_EMIT, S_EMITW
    } state_t;

    // reply byte sources
    typedef enum logic [2:0] {
        R_ADDR, R_FUNC, R_B2, R_B3, R_B4, R_B5, R_DATA, R_CRC
    } rsrc_t;

    state_t state_reg;
    logic [7:0] node_reg, gap_lim_reg, crc_exc_reg;
    logic [7:0] buf_mem [BUF_BYTES];
    logic [7:0] buf_q;
    logic [LW-1:0] len_reg, ptr_reg;
    logic receiving_reg;
    logic [7:0] gap_reg;
    logic [15:0] regs_mem [NUM_REGS];
    logic [15:0] regs_q;
    logic [RW-1:0] clr_reg;
    // local read index range check, taken with the request
    logic lread_ok_reg;
    // header fields captured while walking the frame
    logic [7:0] f_b1, f_b2, f_b3, f_b4, f_b5, f_rx0, f_crclo, f_crchi;
    // reply builder
    logic [7:0] r_b1, r_b2, r_b3, r_b4, r_b5;
    logic [5:0] r_cnt_reg;
    logic [2:0] r_hdr_reg;
    logic        r_is_read, r_is_write, r_hi_reg, r_crc_hi_reg;
    logic [RW-1:0] r_ridx_reg;
    logic [7:0] r_byte;
    logic strobe_reg, kind_reg, last_reg;
    logic [15:0] data_reg;

    // shared crc unit
    logic crc_clear, crc_en;
    logic [7:0] crc_din;
    logic [15:0] crc_val;
    mbrtu_crc u_crc (.clk(clk), .rst_n(rst_n), .clear(crc_clear), .en(crc_en),
        .din(crc_din), .crc(crc_val));

    wire accept = start && !busy;
    assign busy = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign strobe = strobe_reg;
    assign kind = kind_reg;
    assign data = data_reg;
    assign last = last_reg;

    // buffer: a byte is stored at wr_pos while wr_pos is below BUF_FULL; later bytes are dropped
    wire [LW-1:0] wr_pos = receiving_reg ? len_reg : '0;
    always_ff @(posedge clk)
    begin
        if (accept && opcode == mbrtu_pkg::OP_RX_BYTE && wr_pos < BUF_FULL)
            buf_mem[wr_pos[BW-1:0]] <= rx_byte;
        buf_q <= buf_mem[ptr_reg[BW-1:0]];
    end

    // register file: one write port, one read port
    logic rg_we;
    logic [RW-1:0] rg_wa, rg_ra;
    logic [15:0] rg_wd;
    always_ff @(posedge clk)
    begin
        if (rg_we)
            regs_mem[rg_wa] <= rg_wd;
        regs_q <= regs_mem[rg_ra];
    end

    wire [15:0] f_addr = {f_b2, f_b3};
    wire [15:0] f_arg  = {f_b4, f_b5};
    wire [16:0] rd_end = {1'b0, f_addr} + {1'b0, f_arg};
    wire lidx_ok = {1'b0, reg_index} < NREGS17;

    always_comb
    begin
        rg_we = 1'b0;
        rg_wa = reg_index[RW-1:0];
        rg_wd = reg_value;
        rg_ra = (state_reg == S_IDLE) ? reg_index[RW-1:0] : r_ridx_reg;
        if (state_reg == S_CLEAR)
        begin
            rg_we = 1'b1;
            rg_wa = clr_reg;
            rg_wd = '0;
        end
        else if (accept && opcode == mbrtu_pkg::OP_LWRITE && lidx_ok)
            rg_we = 1'b1;
        else if (state_reg == S_DECIDE && f_b1 == mbrtu_pkg::FN_WRITE
                 && {1'b0, f_addr} < NREGS17)
        begin
            rg_we = 1'b1;
            rg_wa = f_addr[RW-1:0];
            rg_wd = f_arg;
        end
    end

    // current reply byte
    always_comb
    begin
        unique case (rsrc_t'(r_hdr_reg))
            R_ADDR:  r_byte = node_reg;
            R_FUNC:  r_byte = r_b1;
            R_B2:    r_byte = r_b2;
            R_B3:    r_byte = r_b3;
            R_B4:    r_byte = r_b4;
            R_B5:    r_byte = r_b5;
            R_DATA:  r_byte = r_hi_reg ? regs_q[15:8] : regs_q[7:0];
            R_CRC:   r_byte = r_crc_hi_reg ? crc_val[15:8] : crc_val[7:0];
            default: r_byte = 8'h00;
        endcase
    end

    wire walking = (state_reg == S_CRCRUN);
    wire emitting = (state_reg == S_EMIT);
    // restart the crc before the frame walk, and for the reply once the frame check has been read
    assign crc_clear = (state_reg == S_FETCH) || (state_reg == S_CRCCMP)
                    || (state_reg == S_DECIDE);
    assign crc_en = (walking && ptr_reg <= len_reg - LW'(2) && ptr_reg != 0
                     && (ptr_reg - LW'(1)) < len_reg - LW'(2))
                  || (emitting && rsrc_t'(r_hdr_reg) != R_CRC);
    assign crc_din = walking ? buf_q : r_byte;

    // next header slot after the current one
    function automatic logic [2:0] next_slot(input logic [2:0] cur, input logic rd,
                                             input logic wr);
        rsrc_t c;
        c = rsrc_t'(cur);
        unique case (c)
            R_ADDR:  next_slot = R_FUNC;
            R_FUNC:  next_slot = R_B2;
            R_B2:    next_slot = (rd) ? R_DATA : (wr ? R_B3 : R_CRC);
            R_B3:    next_slot = R_B4;
            R_B4:    next_slot = R_B5;
            R_B5:    next_slot = R_CRC;
            default: next_slot = R_CRC;
        endcase
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            node_reg <= 8'd1;
            gap_lim_reg <= 8'd3;
            crc_exc_reg <= 8'd4;
            len_reg <= '0;
            ptr_reg <= '0;
            receiving_reg <= 1'b0;
            gap_reg <= '0;
            lread_ok_reg <= 1'b0;
            strobe_reg <= 1'b0;
            kind_reg <= 1'b0;
            last_reg <= 1'b0;
            data_reg <= '0;
            r_cnt_reg <= '0;
            r_hdr_reg <= '0;
            r_hi_reg <= 1'b0;
            r_crc_hi_reg <= 1'b0;
            r_ridx_reg <= '0;
            r_is_read <= 1'b0;
            r_is_write <= 1'b0;
            {f_b1, f_b2, f_b3, f_b4, f_b5, f_rx0, f_crclo, f_crchi} <= '0;
            {r_b1, r_b2, r_b3, r_b4, r_b5} <= '0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    mbrtu_pkg::CFG_NODE_ADDR: node_reg <= cfg_data;
                    mbrtu_pkg::CFG_GAP_TICKS: gap_lim_reg <= cfg_data;
                    mbrtu_pkg::CFG_CRC_EXC:   crc_exc_reg <= cfg_data;
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + RW'(1);
                    if (32'(clr_reg) == NUM_REGS - 1)
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (opcode)
                            mbrtu_pkg::OP_RX_BYTE:
                            begin
                                receiving_reg <= 1'b1;
                                gap_reg <= '0;
                                if (wr_pos < BUF_FULL)
                                    len_reg <= wr_pos + LW'(1);
                                else
                                    len_reg <= wr_pos;
                            end
                            mbrtu_pkg::OP_TICK:
                            begin
                                if (receiving_reg)
                                begin
                                    if (gap_reg < gap_lim_reg)
                                        gap_reg <= gap_reg + 8'd1;
                                    else
                                    begin
                                        receiving_reg <= 1'b0;
                                        gap_reg <= '0;
                                        ptr_reg <= '0;
                                        state_reg <= S_FETCH;
                                    end
                                end
                            end
                            mbrtu_pkg::OP_LWRITE: ;
                            mbrtu_pkg::OP_LREAD:
                            begin
                                lread_ok_reg <= lidx_ok;
                                state_reg <= S_LREAD;
                            end
                            default: ;
                        endcase
                    end
                end
                S_LREAD:
                begin
                    strobe_reg <= 1'b1;
                    kind_reg <= 1'b1;
                    last_reg <= 1'b1;
                    data_reg <= lread_ok_reg ? regs_q : mbrtu_pkg::READ_MISS;
                    state_reg <= S_IDLE;
                end
                S_FETCH:
                begin
                    // address ptr 0 issued; clear field captures
                    {f_b1, f_b2, f_b3, f_b4, f_b5, f_rx0, f_crclo, f_crchi} <= '0;
                    if (len_reg < LW'(4))
                        state_reg <= S_IDLE;
                    else
                    begin
                        ptr_reg <= LW'(1);
                        state_reg <= S_CRCRUN;
                    end
                end
                S_CRCRUN:
                begin
                    // buf_q holds byte ptr-1
                    unique case (ptr_reg - LW'(1))
                        LW'(0): f_rx0 <= buf_q;
                        LW'(1): f_b1 <= buf_q;
                        LW'(2): f_b2 <= buf_q;
                        LW'(3): f_b3 <= buf_q;
                        LW'(4): f_b4 <= buf_q;
                        LW'(5): f_b5 <= buf_q;
                        default: ;
                    endcase
                    if (ptr_reg - LW'(1) == len_reg - LW'(2))
                        f_crclo <= buf_q;
                    if (ptr_reg == len_reg)
                    begin
                        f_crchi <= buf_q;
                        state_reg <= S_CRCCMP;
                    end
                    else
                        ptr_reg <= ptr_reg + LW'(1);
                end
                S_CRCCMP:
                begin
                    r_hdr_reg <= R_ADDR;
                    r_crc_hi_reg <= 1'b0;
                    r_hi_reg <= 1'b1;
                    r_is_read <= 1'b0;
                    r_is_write <= 1'b0;
                    if (f_rx0 != node_reg)
                        state_reg <= S_IDLE;
                    else if (f_crclo != crc_val[7:0] || f_crchi != crc_val[15:8])
                    begin
                        r_b1 <= f_b1 | mbrtu_pkg::EXC_FLAG;
                        r_b2 <= crc_exc_reg;
                        state_reg <= S_EMIT;
                    end
                    else
                        state_reg <= S_DECIDE;
                end
                S_DECIDE:
                begin
                    if (f_b1 == mbrtu_pkg::FN_READ)
                    begin
                        if (f_arg > 16'(mbrtu_pkg::READ_CAP) || rd_end > NREGS17)
                        begin
                            r_b1 <= f_b1 | mbrtu_pkg::EXC_FLAG;
                            r_b2 <= mbrtu_pkg::EXC_ILL_ADDR;
                            state_reg <= S_EMIT;
                        end
                        else
                        begin
                            r_is_read <= (f_arg != 0);
                            r_b1 <= mbrtu_pkg::FN_READ;
                            r_b2 <= {f_b5[6:0], 1'b0};
                            r_cnt_reg <= {f_b5[4:0], 1'b0};
                            r_ridx_reg <= f_addr[RW-1:0];
                            state_reg <= S_RDREG;
                        end
                    end
                    else if (f_b1 == mbrtu_pkg::FN_WRITE)
                    begin
                        r_b1 <= f_b1 | mbrtu_pkg::EXC_FLAG;
                        r_b2 <= mbrtu_pkg::EXC_ILL_ADDR;
                        if ({1'b0, f_addr} < NREGS17)
                        begin
                            r_is_write <= 1'b1;
                            r_b1 <= mbrtu_pkg::FN_WRITE;
                            r_b2 <= f_b2;
                            r_b3 <= f_b3;
                            r_b4 <= f_b4;
                            r_b5 <= f_b5;
                        end
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        r_b1 <= f_b1 | mbrtu_pkg::EXC_FLAG;
                        r_b2 <= mbrtu_pkg::EXC_ILL_FUNC;
                        state_reg <= S_EMIT;
                    end
                end
                S_RDREG:
                    state_reg <= S_EMIT;   // register read settles
                S_EMIT:
                begin
                    strobe_reg <= 1'b1;
                    kind_reg <= 1'b0;
                    data_reg <= {8'h00, r_byte};
                    last_reg <= (rsrc_t'(r_hdr_reg) == R_CRC) && r_crc_hi_reg;
                    state_reg <= S_EMITW;
                    if (rsrc_t'(r_hdr_reg) == R_CRC)
                    begin
                        r_crc_hi_reg <= 1'b1;
                        if (r_crc_hi_reg)
                            state_reg <= S_IDLE;
                    end
                    else if (rsrc_t'(r_hdr_reg) == R_DATA)
                    begin
                        r_hi_reg <= !r_hi_reg;
                        r_cnt_reg <= r_cnt_reg - 6'd1;
                        if (!r_hi_reg)
                            r_ridx_reg <= r_ridx_reg + RW'(1);
                        if (r_cnt_reg == 6'd1)
                            r_hdr_reg <= R_CRC;
                    end
                    else
                        r_hdr_reg <= next_slot(r_hdr_reg, r_is_read, r_is_write);
                end
                S_EMITW:
                    state_reg <= S_EMIT;   // lets crc and register read settle
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // no reply strobe while taking requests
    ap_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && $past(state_reg) == S_IDLE) |-> !strobe_reg)
        else $error("strobe while idle");
    // local read answers in the cycle after its state
    ap_lread: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LREAD) |=> (strobe_reg && kind_reg && last_reg))
        else $error("local read lost");
    // reply bytes carry kind zero
    ap_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && $past(state_reg) == S_EMIT) |-> !kind_reg)
        else $error("bad kind");
    // last byte returns to idle
    ap_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && last_reg && !kind_reg) |-> state_reg == S_IDLE)
        else $error("reply did not end");
endmodule
`default_nettype wire

// File: tb/tb_modbus_rtu_slave_engine_core.sv
// self-checking testbench for the modbus rtu slave engine top level
`default_nettype none
module tb_modbus_rtu_slave_engine_core;
    localparam int NREG = mbrtu_pkg::NUM_REGS_DEF;
    localparam int NBUF = mbrtu_pkg::BUF_BYTES_DEF;

    // one result as seen on the strobe side
    typedef struct packed {
        logic        kind;
        logic [15:0] data;
        logic        last;
    } reply_t;

    // one row of the directed table; has_exp marks rows whose reply is typed in
    typedef struct {
        logic [1:0]  op;
        logic [7:0]  rxb;
        logic [15:0] idx;
        logic [15:0] val;
        bit          has_exp;
        logic [15:0] exp_data;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  opcode;
    logic [7:0]  rx_byte;
    logic [15:0] reg_index;
    logic [15:0] reg_value;
    logic        strobe;
    logic        kind;
    logic [15:0] data;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [7:0]  cfg_data;

    modbus_rtu_slave_engine_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .opcode    (opcode),
        .rx_byte   (rx_byte),
        .reg_index (reg_index),
        .reg_value (reg_value),
        .strobe    (strobe),
        .kind      (kind),
        .data      (data),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state: configuration copy
    logic [7:0]  m_node;
    logic [7:0]  m_gap_limit;
    logic [7:0]  m_crc_exc;
    // predictor state: receive side and register file
    logic [7:0]  m_buf [NBUF];
    int          m_len;
    bit          m_rx_active;
    logic [7:0]  m_gap;
    logic [15:0] m_regs [NREG];

    reply_t      pending_replies [$];
    int          n_errors;
    int          n_requests;
    int          n_replies;
    int          n_frames;

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // crc-16 over a byte array, poly 0xA001, init 0xFFFF
    function automatic logic [15:0] modbus_crc(input logic [7:0] b [], input int n);
        logic [15:0] c;
        c = mbrtu_pkg::CRC_INIT;
        for (int i = 0; i < n; i++)
        begin
            c = c ^ {8'h00, b[i]};
            for (int k = 0; k < 8; k++)
            begin
                if (c[0])
                    c = (c >> 1) ^ mbrtu_pkg::CRC_POLY;
                else
                    c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] frame_at(input int pos);
        if (pos < m_len && pos < NBUF)
            return m_buf[pos];
        return 8'h00;
    endfunction

    // push a finished reply byte list onto the expected queue
    task automatic queue_reply(input logic [7:0] r [], input int n);
        reply_t e;
        for (int k = 0; k < n; k++)
        begin
            e.kind = 1'b0;
            e.data = {8'h00, r[k]};
            e.last = (k == n - 1);
            pending_replies.push_back(e);
        end
        n_frames++;
    endtask

    // adds crc to reply of n bytes and returns the new length
    function automatic int seal_reply(ref logic [7:0] r [], input int n);
        logic [15:0] c;
        c = modbus_crc(r, n);
        r[n]     = c[7:0];
        r[n + 1] = c[15:8];
        return n + 2;
    endfunction

    function automatic int exception_reply(ref logic [7:0] r [], input logic [7:0] code);
        r[0] = m_node;
        r[1] = frame_at(1) | mbrtu_pkg::EXC_FLAG;
        r[2] = code;
        return seal_reply(r, 3);
    endfunction

    // handle a completed frame in the predictor
    task automatic decode_frame();
        logic [7:0]  r [];
        logic [7:0]  fb [];
        logic [15:0] c;
        logic [7:0]  fn;
        int          addr;
        int          arg;
        int          n;
        r = new[NBUF + 8];
        if (m_len < 4 || frame_at(0) != m_node)
            return;
        fb = new[NBUF];
        for (int i = 0; i < NBUF; i++)
            fb[i] = m_buf[i];
        c = modbus_crc(fb, m_len - 2);
        if (frame_at(m_len - 2) != c[7:0] || frame_at(m_len - 1) != c[15:8])
        begin
            n = exception_reply(r, m_crc_exc);
            queue_reply(r, n);
            return;
        end
        fn   = frame_at(1);
        addr = {frame_at(2), frame_at(3)};
        arg  = {frame_at(4), frame_at(5)};
        if (fn == mbrtu_pkg::FN_READ)
        begin
            if (arg > mbrtu_pkg::READ_CAP || addr + arg > NREG)
                n = exception_reply(r, mbrtu_pkg::EXC_ILL_ADDR);
            else
            begin
                r[0] = m_node;
                r[1] = mbrtu_pkg::FN_READ;
                r[2] = 8'(2 * arg);
                n = 3;
                for (int i = addr; i < addr + arg; i++)
                begin
                    r[n++] = m_regs[i][15:8];
                    r[n++] = m_regs[i][7:0];
                end
                n = seal_reply(r, n);
            end
        end
        else if (fn == mbrtu_pkg::FN_WRITE)
        begin
            if (addr >= NREG)
                n = exception_reply(r, mbrtu_pkg::EXC_ILL_ADDR);
            else
            begin
                m_regs[addr] = 16'(arg);
                r[0] = m_node;
                r[1] = mbrtu_pkg::FN_WRITE;
                r[2] = 8'(addr >> 8);
                r[3] = 8'(addr);
                r[4] = 8'(arg >> 8);
                r[5] = 8'(arg);
                n = seal_reply(r, 6);
            end
        end
        else
            n = exception_reply(r, mbrtu_pkg::EXC_ILL_FUNC);
        queue_reply(r, n);
    endtask

    // predictor step for one accepted request
    task automatic predict_request(input logic [1:0] op, input logic [7:0] rxb,
                                   input logic [15:0] idx, input logic [15:0] val);
        reply_t e;
        case (op)
            mbrtu_pkg::OP_RX_BYTE:
            begin
                if (!m_rx_active)
                begin
                    for (int i = 0; i < NBUF; i++)
                        m_buf[i] = 8'h00;
                    m_len = 0;
                    m_rx_active = 1'b1;
                end
                if (m_len < NBUF)
                    m_buf[m_len++] = rxb;
                m_gap = 8'h00;
            end
            mbrtu_pkg::OP_TICK:
            begin
                if (m_rx_active)
                begin
                    if (m_gap < m_gap_limit)
                        m_gap++;
                    else
                    begin
                        m_rx_active = 1'b0;
                        m_gap = 8'h00;
                        decode_frame();
                    end
                end
            end
            mbrtu_pkg::OP_LWRITE:
            begin
                if (idx < NREG)
                    m_regs[idx] = val;
            end
            default:
            begin
                e.kind = 1'b1;
                e.data = (idx < NREG) ? m_regs[idx] : mbrtu_pkg::READ_MISS;
                e.last = 1'b1;
                pending_replies.push_back(e);
            end
        endcase
    endtask

    // result checker: strobe sampled at the rising edge
    always @(posedge clk)
    begin
        reply_t e;
        if (rst_n && strobe)
        begin
            n_replies++;
            if (pending_replies.size() == 0)
            begin
                $error("unexpected result kind=%0d data=%h last=%0d", kind, data, last);
                n_errors++;
            end
            else
            begin
                e = pending_replies.pop_front();
                if (kind !== e.kind)
                begin
                    $error("kind: expected %0d, got %0d", e.kind, kind);
                    n_errors++;
                end
                if (data !== e.data)
                begin
                    $error("data: expected %h, got %h", e.data, data);
                    n_errors++;
                end
                if (last !== e.last)
                begin
                    $error("last: expected %0d, got %0d", e.last, last);
                    n_errors++;
                end
            end
        end
    end

    // burst of random idle cycles on the sender side; start drops for the burst
    bit idling_on;
    task automatic maybe_idle();
        int gap;
        if (idling_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 11);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // issue one request; start stays high across back-to-back requests
    task automatic send_request(input logic [1:0] op, input logic [7:0] rxb,
                                input logic [15:0] idx, input logic [15:0] val);
        start     <= 1'b1;
        opcode    <= op;
        rx_byte   <= rxb;
        reg_index <= idx;
        reg_value <= val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_request(op, rxb, idx, val);
        n_requests++;
        @(negedge clk);
        maybe_idle();
    endtask

    // stop sending, wait for every expected result, then let the block drain
    task automatic drain();
        start <= 1'b0;
        while (pending_replies.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        while (busy)
            @(negedge clk);
    endtask

    // configuration write while idle
    task automatic write_config(input logic [1:0] ci, input logic [7:0] cd);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= ci;
        cfg_data  <= cd;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (ci)
            mbrtu_pkg::CFG_NODE_ADDR: m_node      = cd;
            mbrtu_pkg::CFG_GAP_TICKS: m_gap_limit = cd;
            default:                  m_crc_exc   = cd;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic end_frame();
        for (int i = 0; i <= m_gap_limit; i++)
            send_request(mbrtu_pkg::OP_TICK, 8'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // build and send a request frame; bad_crc flips one bit of the check bytes
    task automatic send_frame(input logic [7:0] addr, input logic [7:0] fn,
                              input logic [15:0] a, input logic [15:0] b, input bit bad_crc);
        logic [7:0]  f [];
        logic [15:0] c;
        f = new[8];
        f[0] = addr;
        f[1] = fn;
        f[2] = a[15:8];
        f[3] = a[7:0];
        f[4] = b[15:8];
        f[5] = b[7:0];
        c = modbus_crc(f, 6);
        if (bad_crc)
            c = c ^ 16'(1 << $urandom_range(0, 15));
        f[6] = c[7:0];
        f[7] = c[15:8];
        for (int i = 0; i < 8; i++)
            send_request(mbrtu_pkg::OP_RX_BYTE, f[i], 16'($urandom), 16'($urandom));
        end_frame();
    endtask

    // junk frame of arbitrary length, up past the buffer size
    task automatic send_noise_frame(input int n);
        for (int i = 0; i < n; i++)
            send_request(mbrtu_pkg::OP_RX_BYTE,
                         (i == 0 && $urandom_range(0, 1)) ? m_node : 8'($urandom),
                         16'($urandom), 16'($urandom));
        end_frame();
    endtask

    // directed table: local port extremes, then a frame too short to answer
    row_t table_rows [] = '{
        '{mbrtu_pkg::OP_LREAD,   8'h00, 16'd0,    16'h0000, 1'b1, 16'h0000},
        '{mbrtu_pkg::OP_LREAD,   8'h00, 16'd31,   16'h0000, 1'b1, 16'h0000},
        '{mbrtu_pkg::OP_LREAD,   8'h00, 16'd32,   16'h0000, 1'b1, mbrtu_pkg::READ_MISS},
        '{mbrtu_pkg::OP_LREAD,   8'h00, 16'hFFFF, 16'h0000, 1'b1, mbrtu_pkg::READ_MISS},
        '{mbrtu_pkg::OP_LWRITE,  8'h00, 16'd0,    16'hFFFF, 1'b0, 16'h0000},
        '{mbrtu_pkg::OP_LWRITE,  8'h00, 16'd31,   16'h8001, 1'b0, 16'h0000},
        '{mbrtu_pkg::OP_LWRITE,  8'h00, 16'hFFFF, 16'h1234, 1'b0, 16'h0000},
        '{mbrtu_pkg::OP_LREAD,   8'h00, 16'd0,    16'h0000, 1'b1, 16'hFFFF},
        '{mbrtu_pkg::OP_LREAD,   8'h00, 16'd31,   16'h0000, 1'b1, 16'h8001},
        '{mbrtu_pkg::OP_TICK,    8'hFF, 16'd0,    16'h0000, 1'b0, 16'h0000},
        '{mbrtu_pkg::OP_LWRITE,  8'h00, 16'd5,    16'hA5A5, 1'b0, 16'h0000},
        '{mbrtu_pkg::OP_LREAD,   8'h00, 16'd5,    16'h0000, 1'b0, 16'h0000},
        // a two byte frame is too short to answer
        '{mbrtu_pkg::OP_RX_BYTE, 8'h01, 16'd0,    16'h0000, 1'b0, 16'h0000},
        '{mbrtu_pkg::OP_RX_BYTE, 8'h03, 16'd0,    16'h0000, 1'b0, 16'h0000},
        '{mbrtu_pkg::OP_TICK,    8'h00, 16'd0,    16'h0000, 1'b0, 16'h0000},
        '{mbrtu_pkg::OP_TICK,    8'h00, 16'd0,    16'h0000, 1'b0, 16'h0000},
        '{mbrtu_pkg::OP_TICK,    8'h00, 16'd0,    16'h0000, 1'b0, 16'h0000},
        '{mbrtu_pkg::OP_TICK,    8'h00, 16'd0,    16'h0000, 1'b0, 16'h0000}
    };

    initial
    begin
        logic [1:0]  rop;
        logic [15:0] a;
        logic [15:0] b;
        logic [7:0]  fn;
        int          pick;

        rst_n     = 1'b0;
        start     = 1'b0;
        opcode    = mbrtu_pkg::OP_TICK;
        rx_byte   = 8'h00;
        reg_index = 16'h0000;
        reg_value = 16'h0000;
        cfg_valid = 1'b0;
        cfg_index = mbrtu_pkg::CFG_NODE_ADDR;
        cfg_data  = 8'h00;
        n_errors  = 0;
        n_requests = 0;
        n_replies = 0;
        n_frames  = 0;
        idling_on = 1'b0;

        m_node      = 8'd1;
        m_gap_limit = 8'd3;
        m_crc_exc   = 8'd4;
        m_len       = 0;
        m_rx_active = 1'b0;
        m_gap       = 8'h00;
        for (int i = 0; i < NBUF; i++)
            m_buf[i] = 8'h00;
        for (int i = 0; i < NREG; i++)
            m_regs[i] = 16'h0000;

        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        while (busy)
            @(negedge clk);

        // directed rows; typed-in expectations are checked against the predictor
        foreach (table_rows[i])
        begin
            if (table_rows[i].has_exp && table_rows[i].exp_data !==
                ((table_rows[i].idx < NREG) ? m_regs[table_rows[i].idx]
                                            : mbrtu_pkg::READ_MISS))
            begin
                $error("data: expected %h, got %h (table row %0d)", table_rows[i].exp_data,
                       m_regs[table_rows[i].idx % NREG], i);
                n_errors++;
            end
            send_request(table_rows[i].op, table_rows[i].rxb, table_rows[i].idx,
                         table_rows[i].val);
        end

        // frame level directed cases at reset config
        send_frame(8'd1, mbrtu_pkg::FN_READ, 16'd0, 16'd29, 1'b0);      // largest read
        send_frame(8'd1, mbrtu_pkg::FN_READ, 16'd0, 16'd30, 1'b0);      // read over the cap
        send_frame(8'd1, mbrtu_pkg::FN_READ, 16'd31, 16'd2, 1'b0);      // read past the end
        send_frame(8'd1, mbrtu_pkg::FN_READ, 16'd4, 16'd0, 1'b0);       // zero count read
        send_frame(8'd1, mbrtu_pkg::FN_WRITE, 16'd31, 16'hBEEF, 1'b0);
        send_frame(8'd1, mbrtu_pkg::FN_WRITE, 16'd32, 16'h0001, 1'b0);  // write out of range
        send_frame(8'd1, 8'h7F, 16'd0, 16'd0, 1'b0);                    // unknown function
        send_frame(8'd1, mbrtu_pkg::FN_READ, 16'd0, 16'd1, 1'b1);       // bad crc
        send_frame(8'd9, mbrtu_pkg::FN_READ, 16'd0, 16'd1, 1'b0);       // foreign address
        send_noise_frame(NBUF + 6);                                      // overflow

        // extremes of the config registers
        write_config(mbrtu_pkg::CFG_GAP_TICKS, 8'd1);
        write_config(mbrtu_pkg::CFG_NODE_ADDR, 8'd0);
        write_config(mbrtu_pkg::CFG_CRC_EXC, 8'hFF);
        send_frame(8'd0, mbrtu_pkg::FN_READ, 16'd0, 16'd1, 1'b1);
        send_frame(8'd0, mbrtu_pkg::FN_WRITE, 16'd0, 16'h00FF, 1'b0);
        write_config(mbrtu_pkg::CFG_NODE_ADDR, 8'hFF);
        write_config(mbrtu_pkg::CFG_CRC_EXC, 8'h00);
        send_frame(8'hFF, mbrtu_pkg::FN_READ, 16'd0, 16'd2, 1'b1);
        send_frame(8'hFF, mbrtu_pkg::FN_READ, 16'd0, 16'd3, 1'b0);

        // random phase, several config settings
        idling_on = 1'b1;
        for (int phase = 0; phase < 4; phase++)
        begin
            write_config(mbrtu_pkg::CFG_NODE_ADDR, 8'($urandom));
            write_config(mbrtu_pkg::CFG_GAP_TICKS,
                         (phase == 3) ? 8'd1 : 8'($urandom_range(1, 6)));
            write_config(mbrtu_pkg::CFG_CRC_EXC, 8'($urandom));
            if (phase == 3)
                idling_on = 1'b0;
            for (int j = 0; j < 4; j++)
            begin
                pick = $urandom_range(0, 9);
                a = 16'($urandom_range(0, 34));
                b = 16'($urandom_range(0, 31));
                if ($urandom_range(0, 7) == 0)
                begin
                    a = 16'($urandom);
                    b = 16'($urandom);
                end
                fn = ($urandom_range(0, 1)) ? mbrtu_pkg::FN_READ : mbrtu_pkg::FN_WRITE;
                if (pick < 6)
                    send_frame(m_node, fn, a,
                               (fn == mbrtu_pkg::FN_WRITE) ? 16'($urandom) : b, 1'b0);
                else if (pick == 6)
                    send_frame(m_node, 8'($urandom), a, b, $urandom_range(0, 1));
                else if (pick == 7)
                    send_frame(8'($urandom), fn, a, b, 1'b0);
                else if (pick == 8)
                    send_noise_frame($urandom_range(1, 10));
                else
                begin
                    rop = ($urandom_range(0, 1)) ? mbrtu_pkg::OP_LREAD : mbrtu_pkg::OP_LWRITE;
                    send_request(rop, 8'($urandom), ($urandom_range(0, 3) == 0) ?
                                 16'($urandom) : 16'($urandom_range(0, 31)), 16'($urandom));
                    send_request(mbrtu_pkg::OP_TICK, 8'($urandom), 16'($urandom),
                                 16'($urandom));
                end
            end
            // pause until every expected result has come
            drain();
        end

        drain();
        repeat (20) @(negedge clk);
        $display("covered %0d requests, %0d replied frames, %0d results checked",
                 n_requests, n_frames, n_replies);
        $display("local port, read/write/exception/crc/foreign/short/overflow frames");
        if (n_errors == 0 && pending_replies.size() == 0)
            $display("[modbus_rtu_slave_engine_core] OK");
        else
            $display("[modbus_rtu_slave_engine_core] ERROR");
        $finish;
    end

    // watchdog
    initial
    begin
        #20000000;
        $display("[modbus_rtu_slave_engine_core] ERROR");
        $finish;
    end
endmodule
`default_nettype wire
